// File: rtl/lcw_pkg.sv
// ----------------------------------------------------------------------------
// lcw_pkg
// Shared widths, register codes, move codes and helpers for the lattice
// chain wall contact scorer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcw_pkg;

  // Fixed field widths
  localparam int MOVES_W    = 30;
  localparam int PAIR_REG_W = 36;
  localparam int PAIR_IDX_W = 4;
  localparam int RANGE_W    = 4;
  localparam int WMON_W     = 5;
  localparam int PCOUNT_W   = 4;
  localparam int CONTACTS_W = 4;
  localparam int SHIFT_W    = 5;
  localparam int ENERGY_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;

  // Monomers summed per group in the prefix and reduction stages
  localparam int GROUP = 8;

  // Reciprocal precision for the divide by chain length
  localparam int RECIP_K = 16;

  // Output shift saturation limits
  localparam int SHIFT_MAX = 15;
  localparam int SHIFT_MIN = -16;
  localparam int ENERGY_MAX = 255;

  // Register reset values
  localparam logic [RANGE_W-1:0]    RST_WALL_RANGE    = 4'd6;
  localparam logic [WMON_W-1:0]     RST_WALL_MONOMERS = 5'd4;
  localparam logic [PCOUNT_W-1:0]   RST_PAIR_COUNT    = 4'd9;
  localparam logic [PAIR_REG_W-1:0] RST_PAIR_FIRST    = 36'hA98654210;
  localparam logic [PAIR_REG_W-1:0] RST_PAIR_SECOND   = 36'hDEF9AB567;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALL_RANGE    = 3'd0,
    CFG_WALL_MONOMERS = 3'd1,
    CFG_PAIR_COUNT    = 3'd2,
    CFG_PAIR_FIRST    = 3'd3,
    CFG_PAIR_SECOND   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MOVE_PX = 2'd0,
    MOVE_PY = 2'd1,
    MOVE_NY = 2'd2,
    MOVE_NX = 2'd3
  } move_t;

  // Load enables for the two register stages inside one datapath module
  typedef struct packed {
    logic early;
    logic late;
  } stage_en_t;

  function automatic logic signed [1:0] move_dx(input logic [1:0] m);
    logic signed [1:0] d;
    unique case (move_t'(m))
      MOVE_PX:          d = 2'sb01;
      MOVE_NX:          d = 2'sb11;
      MOVE_PY, MOVE_NY: d = 2'sb00;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] move_dy(input logic [1:0] m);
    logic signed [1:0] d;
    unique case (move_t'(m))
      MOVE_PY:          d = 2'sb01;
      MOVE_NY:          d = 2'sb11;
      MOVE_PX, MOVE_NX: d = 2'sb00;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/lcw_decode.sv
// ----------------------------------------------------------------------------
// lcw_decode
// Move decode into monomer coordinates: group-local prefix sums, then
// group bases added in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcw_decode #(
  parameter int CHAIN_LENGTH = 16,
  localparam int CW = $clog2(CHAIN_LENGTH) + 1
) (
  input  logic                          clk,
  input  lcw_pkg::stage_en_t            en,
  input  logic [lcw_pkg::MOVES_W-1:0]   moves,
  output logic signed [CW-1:0]          px [CHAIN_LENGTH],
  output logic signed [CW-1:0]          py [CHAIN_LENGTH]
);

  localparam int NG = (CHAIN_LENGTH + lcw_pkg::GROUP - 1) / lcw_pkg::GROUP;

  logic [1:0]           mv      [CHAIN_LENGTH-1];
  logic signed [CW-1:0] lx_next [CHAIN_LENGTH];
  logic signed [CW-1:0] ly_next [CHAIN_LENGTH];
  logic signed [CW-1:0] tx_next [NG];
  logic signed [CW-1:0] ty_next [NG];
  logic signed [CW-1:0] lx      [CHAIN_LENGTH];
  logic signed [CW-1:0] ly      [CHAIN_LENGTH];
  logic signed [CW-1:0] tx      [NG];
  logic signed [CW-1:0] ty      [NG];
  logic signed [CW-1:0] px_next [CHAIN_LENGTH];
  logic signed [CW-1:0] py_next [CHAIN_LENGTH];

  // moves past the field read as +x
  always_comb begin
    for (int j = 0; j < CHAIN_LENGTH - 1; j++) begin
      mv[j] = 2'(moves >> (2 * j));
    end
  end

  // stage 1: local prefix within each group of monomers, plus group totals
  always_comb begin
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    for (int i = 0; i < CHAIN_LENGTH; i++) begin
      ax = '0;
      ay = '0;
      for (int j = (i / lcw_pkg::GROUP) * lcw_pkg::GROUP; j < i; j++) begin
        ax = ax + CW'(lcw_pkg::move_dx(mv[j]));
        ay = ay + CW'(lcw_pkg::move_dy(mv[j]));
      end
      lx_next[i] = ax;
      ly_next[i] = ay;
    end
    for (int g = 0; g < NG; g++) begin
      ax = '0;
      ay = '0;
      for (int j = g * lcw_pkg::GROUP;
           j < g * lcw_pkg::GROUP + lcw_pkg::GROUP && j < CHAIN_LENGTH - 1; j++) begin
        ax = ax + CW'(lcw_pkg::move_dx(mv[j]));
        ay = ay + CW'(lcw_pkg::move_dy(mv[j]));
      end
      tx_next[g] = ax;
      ty_next[g] = ay;
    end
  end

  always_ff @(posedge clk) begin
    if (en.early) begin
      lx <= lx_next;
      ly <= ly_next;
      tx <= tx_next;
      ty <= ty_next;
    end
  end

  // stage 2: add the running base of earlier groups
  always_comb begin
    logic signed [CW-1:0] bx [NG];
    logic signed [CW-1:0] by [NG];
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    ax = '0;
    ay = '0;
    for (int g = 0; g < NG; g++) begin
      bx[g] = ax;
      by[g] = ay;
      ax = ax + tx[g];
      ay = ay + ty[g];
    end
    for (int i = 0; i < CHAIN_LENGTH; i++) begin
      px_next[i] = bx[i / lcw_pkg::GROUP] + lx[i];
      py_next[i] = by[i / lcw_pkg::GROUP] + ly[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en.late) begin
      px <= px_next;
      py <= py_next;
    end
  end

endmodule

// File: rtl/lcw_geometry.sv
// ----------------------------------------------------------------------------
// lcw_geometry
// Site collision check, contact pair test, and height sum / minimum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcw_geometry #(
  parameter int CHAIN_LENGTH = 16,
  parameter int MAX_PAIRS    = 9,
  localparam int CW = $clog2(CHAIN_LENGTH) + 1,
  localparam int SW = $clog2(CHAIN_LENGTH * (CHAIN_LENGTH - 1) / 2 + 1) + 1
) (
  input  logic                                clk,
  input  lcw_pkg::stage_en_t                  en,
  input  logic signed [CW-1:0]                px [CHAIN_LENGTH],
  input  logic signed [CW-1:0]                py [CHAIN_LENGTH],
  input  logic [lcw_pkg::PCOUNT_W-1:0]        pair_count,
  input  logic [lcw_pkg::PAIR_REG_W-1:0]      pair_first,
  input  logic [lcw_pkg::PAIR_REG_W-1:0]      pair_second,
  output logic                                self_avoiding,
  output logic [lcw_pkg::CONTACTS_W-1:0]      contacts,
  output logic signed [SW-1:0]                y_sum,
  output logic signed [CW-1:0]                y_min,
  output logic signed [CW-1:0]                y_out [CHAIN_LENGTH]
);

  localparam int NG = (CHAIN_LENGTH + lcw_pkg::GROUP - 1) / lcw_pkg::GROUP;
  localparam int IW = $clog2(CHAIN_LENGTH);

  logic                 collide_next;
  logic [MAX_PAIRS-1:0] hit_next;
  logic signed [SW-1:0] gsum_next [NG];
  logic signed [CW-1:0] gmin_next [NG];
  logic                 collide;
  logic [MAX_PAIRS-1:0] hit;
  logic signed [SW-1:0] gsum [NG];
  logic signed [CW-1:0] gmin [NG];
  logic signed [CW-1:0] y3   [CHAIN_LENGTH];
  logic signed [SW-1:0] y_sum_next;
  logic signed [CW-1:0] y_min_next;

  // stage 3: collisions (odd index gaps can never share a site)
  always_comb begin
    collide_next = 1'b0;
    for (int i = 0; i < CHAIN_LENGTH; i++) begin
      for (int j = i + 2; j < CHAIN_LENGTH; j += 2) begin
        if (px[i] == px[j] && py[i] == py[j]) begin
          collide_next = 1'b1;
        end
      end
    end
  end

  // stage 3: contact pairs; slots past the register read as (0,0)
  always_comb begin
    logic [lcw_pkg::PAIR_IDX_W-1:0] a;
    logic [lcw_pkg::PAIR_IDX_W-1:0] b;
    logic [IW-1:0]                  ia;
    logic [IW-1:0]                  ib;
    logic signed [CW:0]             dx;
    logic signed [CW:0]             dy;
    logic                           adj;
    for (int k = 0; k < MAX_PAIRS; k++) begin
      a   = lcw_pkg::PAIR_IDX_W'(pair_first >> (lcw_pkg::PAIR_IDX_W * k));
      b   = lcw_pkg::PAIR_IDX_W'(pair_second >> (lcw_pkg::PAIR_IDX_W * k));
      ia  = IW'(a);
      ib  = IW'(b);
      dx  = (CW + 1)'(px[ia]) - (CW + 1)'(px[ib]);
      dy  = (CW + 1)'(py[ia]) - (CW + 1)'(py[ib]);
      adj = (dx == '0 && (dy == (CW + 1)'(1) || dy == '1)) ||
            (dy == '0 && (dx == (CW + 1)'(1) || dx == '1));
      hit_next[k] = adj && (5'(k) < {1'b0, pair_count}) &&
                    (32'(a) < CHAIN_LENGTH) && (32'(b) < CHAIN_LENGTH);
    end
  end

  // stage 3: per-group height sum and minimum
  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [CW-1:0] mn;
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      mn  = '0;
      for (int i = g * lcw_pkg::GROUP;
           i < g * lcw_pkg::GROUP + lcw_pkg::GROUP && i < CHAIN_LENGTH; i++) begin
        acc = acc + SW'(py[i]);
        if (py[i] < mn) begin
          mn = py[i];
        end
      end
      gsum_next[g] = acc;
      gmin_next[g] = mn;
    end
  end

  always_ff @(posedge clk) begin
    if (en.early) begin
      collide <= collide_next;
      hit     <= hit_next;
      gsum    <= gsum_next;
      gmin    <= gmin_next;
      y3      <= py;
    end
  end

  // stage 4: combine groups
  always_comb begin
    y_sum_next = '0;
    y_min_next = '0;
    for (int g = 0; g < NG; g++) begin
      y_sum_next = y_sum_next + gsum[g];
      if (gmin[g] < y_min_next) begin
        y_min_next = gmin[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.late) begin
      self_avoiding <= !collide;
      contacts      <= lcw_pkg::CONTACTS_W'($countones(hit));
      y_sum         <= y_sum_next;
      y_min         <= y_min_next;
      y_out         <= y3;
    end
  end

endmodule

// File: rtl/lcw_shift.sv
// ----------------------------------------------------------------------------
// lcw_shift
// Vertical shift s = -floor(sum / CHAIN_LENGTH) by reciprocal multiply with
// one correction step, and the placement check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcw_shift #(
  parameter int CHAIN_LENGTH = 16,
  localparam int CW  = $clog2(CHAIN_LENGTH) + 1,
  localparam int SW  = $clog2(CHAIN_LENGTH * (CHAIN_LENGTH - 1) / 2 + 1) + 1,
  localparam int SHW = CW + 1
) (
  input  logic                            clk,
  input  lcw_pkg::stage_en_t              en,
  input  logic signed [SW-1:0]            y_sum,
  input  logic signed [CW-1:0]            y_min,
  input  logic signed [CW-1:0]            y_in [CHAIN_LENGTH],
  input  logic                            saw_in,
  input  logic [lcw_pkg::CONTACTS_W-1:0]  contacts_in,
  output logic signed [SHW-1:0]           shift,
  output logic                            placed,
  output logic signed [CW-1:0]            y_out [CHAIN_LENGTH],
  output logic                            saw_out,
  output logic [lcw_pkg::CONTACTS_W-1:0]  contacts_out
);

  // sum + OFFSET is never negative; floor(sum/L) = floor(n/L) - BIAS
  localparam int BIAS   = (CHAIN_LENGTH - 1) / 2 + 1;
  localparam int OFFSET = CHAIN_LENGTH * BIAS;
  localparam int NW     = $clog2(CHAIN_LENGTH * CHAIN_LENGTH + 1);
  localparam int RECIP  = (1 << lcw_pkg::RECIP_K) / CHAIN_LENGTH;
  localparam int PW     = NW + lcw_pkg::RECIP_K;

  logic signed [NW:0]    n_wide;
  logic [NW-1:0]         n_next;
  logic [NW-1:0]         n5;
  logic [PW-1:0]         prod5;
  logic signed [CW-1:0]  ymin5;
  logic signed [CW-1:0]  y5 [CHAIN_LENGTH];
  logic                  saw5;
  logic [lcw_pkg::CONTACTS_W-1:0] cont5;

  logic [NW-1:0]         q_est;
  logic [NW:0]           q_len;
  logic [NW:0]           rem;
  logic [NW-1:0]         q;
  logic signed [SHW-1:0] shift_next;
  logic signed [SHW:0]   low_height;

  // stage 5: bias and reciprocal multiply
  assign n_wide = (NW + 1)'(y_sum) + (NW + 1)'(OFFSET);
  assign n_next = n_wide[NW-1:0];

  always_ff @(posedge clk) begin
    if (en.early) begin
      n5    <= n_next;
      prod5 <= PW'(n_next) * PW'(RECIP);
      ymin5 <= y_min;
      y5    <= y_in;
      saw5  <= saw_in;
      cont5 <= contacts_in;
    end
  end

  // stage 6: estimate is exact or one low; fix with a single compare
  always_comb begin
    q_est      = prod5[PW-1:lcw_pkg::RECIP_K];
    q_len      = (NW + 1)'(q_est) * (NW + 1)'(CHAIN_LENGTH);
    rem        = (NW + 1)'(n5) - q_len;
    q          = (rem >= (NW + 1)'(CHAIN_LENGTH)) ? q_est + 1'b1 : q_est;
    shift_next = SHW'(BIAS) - SHW'(q);
    low_height = (SHW + 1)'(ymin5) + (SHW + 1)'(shift_next);
  end

  always_ff @(posedge clk) begin
    if (en.late) begin
      shift        <= shift_next;
      placed       <= !low_height[SHW];
      y_out        <= y5;
      saw_out      <= saw5;
      contacts_out <= cont5;
    end
  end

endmodule

// File: rtl/lcw_wall.sv
// ----------------------------------------------------------------------------
// lcw_wall
// Wall energy over the leading monomers, shift saturation, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcw_wall #(
  parameter int CHAIN_LENGTH = 16,
  localparam int CW  = $clog2(CHAIN_LENGTH) + 1,
  localparam int SHW = CW + 1
) (
  input  logic                            clk,
  input  lcw_pkg::stage_en_t              en,
  input  logic [lcw_pkg::RANGE_W-1:0]     wall_range,
  input  logic [lcw_pkg::WMON_W-1:0]      wall_monomers,
  input  logic signed [SHW-1:0]           shift_in,
  input  logic                            placed_in,
  input  logic signed [CW-1:0]            y_in [CHAIN_LENGTH],
  input  logic                            saw_in,
  input  logic [lcw_pkg::CONTACTS_W-1:0]  contacts_in,
  output logic                            self_avoiding,
  output logic [lcw_pkg::CONTACTS_W-1:0]  contacts,
  output logic                            placed,
  output logic signed [lcw_pkg::SHIFT_W-1:0] shift,
  output logic [lcw_pkg::ENERGY_W-1:0]    wall_energy
);

  localparam int NG  = (CHAIN_LENGTH + lcw_pkg::GROUP - 1) / lcw_pkg::GROUP;
  localparam int ETW = $clog2(15 * CHAIN_LENGTH + 1);

  logic [ETW-1:0]        esum_next [NG];
  logic [ETW-1:0]        esum7     [NG];
  logic signed [SHW-1:0] s7;
  logic                  placed7;
  logic                  saw7;
  logic [lcw_pkg::CONTACTS_W-1:0] cont7;

  logic [ETW-1:0]        e_total;
  logic [15:0]           e_wide;
  logic signed [7:0]     s_wide;
  logic [lcw_pkg::ENERGY_W-1:0]      energy_next;
  logic signed [lcw_pkg::SHIFT_W-1:0] shift_next;

  // stage 7: per-monomer wall terms, summed per group.
  // When placed, every shifted height is >= 0, so a term fits in 4 bits.
  always_comb begin
    logic signed [SHW:0]   h;
    logic signed [SHW+1:0] d;
    logic [3:0]            term;
    logic [ETW-1:0]        acc;
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      for (int i = g * lcw_pkg::GROUP;
           i < g * lcw_pkg::GROUP + lcw_pkg::GROUP && i < CHAIN_LENGTH; i++) begin
        h = (SHW + 1)'(y_in[i]) + (SHW + 1)'(shift_in);
        d = (SHW + 2)'(signed'({1'b0, wall_range})) - (SHW + 2)'(h);
        if (placed_in && (6'(i) < {1'b0, wall_monomers}) && d > 0) begin
          term = 4'(d);
        end else begin
          term = '0;
        end
        acc = acc + ETW'(term);
      end
      esum_next[g] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en.early) begin
      esum7   <= esum_next;
      s7      <= shift_in;
      placed7 <= placed_in;
      saw7    <= saw_in;
      cont7   <= contacts_in;
    end
  end

  // stage 8: total, saturate, register result
  always_comb begin
    e_total = '0;
    for (int g = 0; g < NG; g++) begin
      e_total = e_total + esum7[g];
    end
    e_wide = 16'(e_total);
    energy_next = (e_wide > 16'(lcw_pkg::ENERGY_MAX)) ? '1 : e_wide[7:0];

    s_wide = 8'(s7);
    if (s_wide > signed'(8'(lcw_pkg::SHIFT_MAX))) begin
      shift_next = lcw_pkg::SHIFT_W'(lcw_pkg::SHIFT_MAX);
    end else if (s_wide < signed'(8'(lcw_pkg::SHIFT_MIN))) begin
      shift_next = lcw_pkg::SHIFT_W'(lcw_pkg::SHIFT_MIN);
    end else begin
      shift_next = s_wide[lcw_pkg::SHIFT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.late) begin
      self_avoiding <= saw7;
      contacts      <= cont7;
      placed        <= placed7;
      shift         <= shift_next;
      wall_energy   <= energy_next;
    end
  end

endmodule

// File: rtl/lattice_chain_wall_contact_scorer.sv
// ----------------------------------------------------------------------------
// lattice_chain_wall_contact_scorer
// Pipeline depth: 8 register stages from request acceptance to result valid.
// Throughput: one request per cycle unless stalled; stages hold on their own.
// Reset clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scores one square-lattice chain conformation per request.
//
// Pipeline
//   1-2  lcw_decode   : moves -> coordinates (group prefix, then group base)
//   3-4  lcw_geometry : site collisions, contact pairs, height sum and min
//   5-6  lcw_shift    : -floor(sum / CHAIN_LENGTH) by reciprocal multiply,
//                       placement check on the lowest monomer
//   7-8  lcw_wall     : wall terms, energy total with saturation, result reg
//
// Flow control: each stage loads when it is empty or the stage after it loads,
// so bubbles collapse and a new request can be taken while a finished result
// waits at the output if a stage is empty. Stage 8 is the output register.
//
// Configuration writes are taken every cycle (cfg_ready is tied high) and
// take effect at once; the user must make them only while no request is in
// flight (the block does not enforce this); indices past the list are ignored.

module lattice_chain_wall_contact_scorer #(
  parameter int CHAIN_LENGTH = 16,
  parameter int MAX_PAIRS    = 9
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [lcw_pkg::MOVES_W-1:0]         moves,

  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                self_avoiding,
  output logic [lcw_pkg::CONTACTS_W-1:0]      contacts,
  output logic                                placed,
  output logic signed [lcw_pkg::SHIFT_W-1:0]  shift,
  output logic [lcw_pkg::ENERGY_W-1:0]        wall_energy,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int STAGES = 8;
  localparam int CW  = $clog2(CHAIN_LENGTH) + 1;
  localparam int SW  = $clog2(CHAIN_LENGTH * (CHAIN_LENGTH - 1) / 2 + 1) + 1;
  localparam int SHW = CW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lcw_pkg::RANGE_W-1:0]    wall_range;
  logic [lcw_pkg::WMON_W-1:0]     wall_monomers;
  logic [lcw_pkg::PCOUNT_W-1:0]   pair_count;
  logic [lcw_pkg::PAIR_REG_W-1:0] pair_first;
  logic [lcw_pkg::PAIR_REG_W-1:0] pair_second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_range    <= lcw_pkg::RST_WALL_RANGE;
      wall_monomers <= lcw_pkg::RST_WALL_MONOMERS;
      pair_count    <= lcw_pkg::RST_PAIR_COUNT;
      pair_first    <= lcw_pkg::RST_PAIR_FIRST;
      pair_second   <= lcw_pkg::RST_PAIR_SECOND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcw_pkg::CFG_WALL_RANGE:    wall_range    <= cfg_data[lcw_pkg::RANGE_W-1:0];
        lcw_pkg::CFG_WALL_MONOMERS: wall_monomers <= cfg_data[lcw_pkg::WMON_W-1:0];
        lcw_pkg::CFG_PAIR_COUNT:    pair_count    <= cfg_data[lcw_pkg::PCOUNT_W-1:0];
        lcw_pkg::CFG_PAIR_FIRST:    pair_first    <= cfg_data[lcw_pkg::PAIR_REG_W-1:0];
        lcw_pkg::CFG_PAIR_SECOND:   pair_second   <= cfg_data[lcw_pkg::PAIR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and load enables
  // ---------------------------------------------------------------------------
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // a stage may load if it is empty or its content moves on this cycle
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || result_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign item_ready   = en[0];
  assign result_valid = vld[STAGES-1];

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]  px [CHAIN_LENGTH];
  logic signed [CW-1:0]  py [CHAIN_LENGTH];

  logic                  geo_saw;
  logic [lcw_pkg::CONTACTS_W-1:0] geo_contacts;
  logic signed [SW-1:0]  geo_sum;
  logic signed [CW-1:0]  geo_min;
  logic signed [CW-1:0]  geo_y [CHAIN_LENGTH];

  logic signed [SHW-1:0] sh_shift;
  logic                  sh_placed;
  logic signed [CW-1:0]  sh_y [CHAIN_LENGTH];
  logic                  sh_saw;
  logic [lcw_pkg::CONTACTS_W-1:0] sh_contacts;

  lcw_decode #(
    .CHAIN_LENGTH (CHAIN_LENGTH)
  ) u_decode (
    .clk   (clk),
    .en    ('{early: en[0], late: en[1]}),
    .moves (moves),
    .px    (px),
    .py    (py)
  );

  lcw_geometry #(
    .CHAIN_LENGTH (CHAIN_LENGTH),
    .MAX_PAIRS    (MAX_PAIRS)
  ) u_geometry (
    .clk           (clk),
    .en            ('{early: en[2], late: en[3]}),
    .px            (px),
    .py            (py),
    .pair_count    (pair_count),
    .pair_first    (pair_first),
    .pair_second   (pair_second),
    .self_avoiding (geo_saw),
    .contacts      (geo_contacts),
    .y_sum         (geo_sum),
    .y_min         (geo_min),
    .y_out         (geo_y)
  );

  lcw_shift #(
    .CHAIN_LENGTH (CHAIN_LENGTH)
  ) u_shift (
    .clk          (clk),
    .en           ('{early: en[4], late: en[5]}),
    .y_sum        (geo_sum),
    .y_min        (geo_min),
    .y_in         (geo_y),
    .saw_in       (geo_saw),
    .contacts_in  (geo_contacts),
    .shift        (sh_shift),
    .placed       (sh_placed),
    .y_out        (sh_y),
    .saw_out      (sh_saw),
    .contacts_out (sh_contacts)
  );

  lcw_wall #(
    .CHAIN_LENGTH (CHAIN_LENGTH)
  ) u_wall (
    .clk           (clk),
    .en            ('{early: en[6], late: en[7]}),
    .wall_range    (wall_range),
    .wall_monomers (wall_monomers),
    .shift_in      (sh_shift),
    .placed_in     (sh_placed),
    .y_in          (sh_y),
    .saw_in        (sh_saw),
    .contacts_in   (sh_contacts),
    .self_avoiding (self_avoiding),
    .contacts      (contacts),
    .placed        (placed),
    .shift         (shift),
    .wall_energy   (wall_energy)
  );

endmodule
